// File: design/http_request_line_parser_macros.svh
// Assertion macros used by the parser's top-level RTL file.
// They sample on clk and stay quiet while rst is high.
`ifndef HTTP_REQUEST_LINE_PARSER_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HRLP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrlp assertion failed");

`define HRLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrlp assertion failed");

`else

`define HRLP_ASSERT_SAME(label, ante, cons)

`define HRLP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: design/hrlp_pkg.sv
package hrlp_pkg;

  typedef enum logic [1:0] {
    STATUS_NEED = 2'd0,
    STATUS_GET  = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FIELD_METHOD  = 3'd0,
    FIELD_GAP1    = 3'd1,
    FIELD_URL     = 3'd2,
    FIELD_GAP2    = 3'd3,
    FIELD_VERSION = 3'd4
  } field_t;

  typedef struct packed {
    logic       line_phase;
    field_t     field_phase;
    logic [3:0] match_index;
    logic [2:0] url_prefix_count;
    logic       url_ok;
    logic       cr_pending;
    logic       line_nonempty;
    logic       line_error;
    status_t    outcome;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    line_phase:       1'b0,
    field_phase:      FIELD_METHOD,
    match_index:      4'd0,
    url_prefix_count: 3'd0,
    url_ok:           1'b0,
    cr_pending:       1'b0,
    line_nonempty:    1'b0,
    line_error:       1'b0,
    outcome:          STATUS_NEED
  };

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  localparam logic [3:0] METHOD_LEN  = 4'd3;
  localparam logic [3:0] VERSION_LEN = 4'd8;
  localparam logic [2:0] SCHEME_LEN  = 3'd7;

  // Lower-case spellings; incoming letters are folded before comparison.
  localparam logic [7:0] METHOD_WORD [3] = '{8'h67, 8'h65, 8'h74};
  localparam logic [7:0] VERSION_WORD [8] =
    '{8'h68, 8'h74, 8'h74, 8'h70, 8'h2f, 8'h31, 8'h2e, 8'h31};
  localparam logic [7:0] SCHEME_WORD [7] =
    '{8'h68, 8'h74, 8'h74, 8'h70, 8'h3a, 8'h2f, 8'h2f};

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

endpackage

// File: design/hrlp_step.sv
module hrlp_step (
  input  hrlp_pkg::parse_state_t st,
  input  logic [7:0]             data_byte,
  input  logic                   new_request,
  output hrlp_pkg::parse_state_t st_next
);

  function automatic hrlp_pkg::parse_state_t url_char(
    input hrlp_pkg::parse_state_t s, input logic [7:0] c);
    hrlp_pkg::parse_state_t r;
    logic [7:0] f;
    r = s;
    f = hrlp_pkg::fold_case(c);
    if (!s.url_ok) begin
      priority if (s.url_prefix_count == 3'd0) begin
        priority if (c == hrlp_pkg::CHAR_SLASH) begin
          r.url_ok = 1'b1;
        end else if (f == hrlp_pkg::SCHEME_WORD[0]) begin
          r.url_prefix_count = 3'd1;
        end else begin
          r.line_error = 1'b1;
        end
      end else if (s.url_prefix_count < hrlp_pkg::SCHEME_LEN) begin
        if (f == hrlp_pkg::SCHEME_WORD[s.url_prefix_count]) begin
          r.url_prefix_count = s.url_prefix_count + 3'd1;
        end else begin
          r.line_error = 1'b1;
        end
      end else begin
        // After a full scheme the URL only waits for its first slash.
        if (c == hrlp_pkg::CHAR_SLASH) begin
          r.url_ok = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic hrlp_pkg::parse_state_t request_char(
    input hrlp_pkg::parse_state_t s, input logic [7:0] c);
    hrlp_pkg::parse_state_t r;
    logic [7:0] f;
    logic       blank;
    r = s;
    f = hrlp_pkg::fold_case(c);
    blank = hrlp_pkg::is_blank(c);
    unique case (s.field_phase)
      hrlp_pkg::FIELD_METHOD: begin
        priority if (blank) begin
          if (s.match_index != hrlp_pkg::METHOD_LEN) begin
            r.line_error = 1'b1;
          end
          r.field_phase = hrlp_pkg::FIELD_GAP1;
        end else if (s.match_index < hrlp_pkg::METHOD_LEN &&
                     f == hrlp_pkg::METHOD_WORD[s.match_index[1:0]]) begin
          r.match_index = s.match_index + 4'd1;
        end else begin
          r.line_error = 1'b1;
        end
      end
      hrlp_pkg::FIELD_GAP1: begin
        if (!blank) begin
          r.field_phase = hrlp_pkg::FIELD_URL;
          r.url_prefix_count = 3'd0;
          r.url_ok = 1'b0;
          r = url_char(r, c);
        end
      end
      hrlp_pkg::FIELD_URL: begin
        if (blank) begin
          if (!s.url_ok) begin
            r.line_error = 1'b1;
          end
          r.field_phase = hrlp_pkg::FIELD_GAP2;
        end else begin
          r = url_char(r, c);
        end
      end
      hrlp_pkg::FIELD_GAP2: begin
        if (!blank) begin
          r.field_phase = hrlp_pkg::FIELD_VERSION;
          if (f == hrlp_pkg::VERSION_WORD[0]) begin
            r.match_index = 4'd1;
          end else begin
            r.match_index = 4'd0;
            r.line_error = 1'b1;
          end
        end
      end
      default: begin
        // Version field; unused phase codes behave the same way.
        if (!blank && s.match_index < hrlp_pkg::VERSION_LEN &&
            f == hrlp_pkg::VERSION_WORD[s.match_index[2:0]]) begin
          r.match_index = s.match_index + 4'd1;
        end else begin
          r.line_error = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic hrlp_pkg::parse_state_t end_of_line(
    input hrlp_pkg::parse_state_t s);
    hrlp_pkg::parse_state_t r;
    r = s;
    priority if (!s.line_phase) begin
      if (!s.line_error && s.field_phase == hrlp_pkg::FIELD_VERSION &&
          s.match_index == hrlp_pkg::VERSION_LEN) begin
        r.line_phase = 1'b1;
        r.line_nonempty = 1'b0;
      end else begin
        r.outcome = hrlp_pkg::STATUS_BAD;
      end
    end else if (!s.line_nonempty) begin
      r.outcome = hrlp_pkg::STATUS_GET;
    end else begin
      r.line_nonempty = 1'b0;
    end
    return r;
  endfunction

  hrlp_pkg::parse_state_t cur;

  always_comb begin
    cur = new_request ? hrlp_pkg::STATE_RESET : st;
    st_next = cur;
    if (cur.outcome == hrlp_pkg::STATUS_NEED) begin
      priority if (cur.cr_pending) begin
        st_next.cr_pending = 1'b0;
        if (data_byte == hrlp_pkg::CHAR_LF) begin
          st_next = end_of_line(st_next);
        end else begin
          st_next.outcome = hrlp_pkg::STATUS_BAD;
        end
      end else if (data_byte == hrlp_pkg::CHAR_CR) begin
        st_next.cr_pending = 1'b1;
      end else if (data_byte == hrlp_pkg::CHAR_LF) begin
        st_next.outcome = hrlp_pkg::STATUS_BAD;
      end else if (!cur.line_phase) begin
        st_next = request_char(cur, data_byte);
      end else begin
        st_next.line_nonempty = 1'b1;
      end
    end
  end

endmodule

// File: design/http_request_line_parser.sv
// HTTP request-line parser, one byte per transaction. Each input byte
// yields exactly one output transaction carrying the status after that
// byte (need more, complete GET request, bad request) and a flag that is
// set once the request line has been accepted and header lines follow.
// Raising tuser with a byte clears the parser before that byte is used.
// The block takes one byte per clock while the output side keeps up; a
// byte passes from an input register through the parser state update into
// an output register, so its status is offered on the output only after the
// byte has moved on from the input register into the output register.
// The rate is set by the combinational state update in hrlp_step, which
// carries the whole per-byte decision.
`include "http_request_line_parser_macros.svh"

module http_request_line_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] new_request
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] status, [2] in_headers, [7:3] zero
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_new;
  logic                   out_free;
  logic                   advance;
  hrlp_pkg::parse_state_t st;
  hrlp_pkg::parse_state_t st_next;
  hrlp_pkg::status_t      status;
  logic                   in_headers;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_new  <= s_tuser;
    end
  end

  hrlp_step u_step (
    .st          (st),
    .data_byte   (in_byte),
    .new_request (in_new),
    .st_next     (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hrlp_pkg::STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status     <= st_next.outcome;
      in_headers <= st_next.line_phase;
    end
  end

  assign m_tdata = {5'b00000, in_headers, status};

  // A reached outcome holds until a new request clears it.
  `HRLP_ASSERT_NEXT(a_outcome_sticky,
    advance && !in_new && st.outcome != hrlp_pkg::STATUS_NEED,
    st.outcome == $past(st.outcome))
  // Header lines are only entered after a fully matched version.
  `HRLP_ASSERT_SAME(a_headers_after_version, st.line_phase,
    st.field_phase == hrlp_pkg::FIELD_VERSION &&
    st.match_index == hrlp_pkg::VERSION_LEN)
  // The URL can only have been accepted once the URL field was reached.
  `HRLP_ASSERT_SAME(a_url_ok_phase, st.url_ok,
    st.field_phase == hrlp_pkg::FIELD_URL ||
    st.field_phase == hrlp_pkg::FIELD_GAP2 ||
    st.field_phase == hrlp_pkg::FIELD_VERSION)
  // A byte held in the input register waits there while the output stalls.
  `HRLP_ASSERT_NEXT(a_input_held, in_valid && !out_free,
    in_valid && $stable(in_byte) && $stable(in_new))
  // The parser state only changes when a byte moves into the output stage.
  `HRLP_ASSERT_NEXT(a_state_quiet, !advance, $stable(st))

endmodule
